// ----- hdl/rac_pkg.sv -----
package rac_pkg;

   // Width of the converted value; bits of the request number above it are ignored.
   localparam int VALUE_WIDTH = 64;

   // Hex digit count, and the working width padded to whole nibbles.
   localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
   localparam int PAD_W = HEX_DIGITS * 4;

   // Decimal digits needed for the largest value: floor(w * log10(2)) + 1.
   localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int BCD_W = DEC_DIGITS * 4;

   // The counter must hold the longest pass, which is PAD_W.
   localparam int CNT_W = $clog2(PAD_W + 1);

   // Supported bases.
   localparam logic [7:0] BASE_BIN = 8'd2;
   localparam logic [7:0] BASE_DEC = 8'd10;
   localparam logic [7:0] BASE_HEX = 8'd16;

   // ASCII offsets for numerals and for the letters A to F.
   localparam logic [6:0] ASCII_ZERO = 7'd48;
   localparam logic [6:0] ASCII_ALPHA_OFS = 7'd55;

   typedef enum logic [1:0] {
      MODE_BIN,
      MODE_DEC,
      MODE_HEX,
      MODE_ERR
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DABBLE,
      ST_SKIP,
      ST_EMIT,
      ST_ERROR
   } state_type;

   typedef struct packed {
      logic [63:0] number;
      logic [7:0]  radix;
   } req_payload_type;

   typedef struct packed {
      logic [6:0] digit_char;
      logic       last_digit;
      logic       base_error;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic     load;
      logic     dabble;
      logic     skip;
      logic     emit;
      logic     emit_err;
      mode_type mode;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic top_zero;
      logic cnt_one;
   } sts_type;

   // Maps a digit value to its uppercase ASCII character.
   function automatic logic [6:0] to_ascii(input logic [3:0] d);
      logic [6:0] r;
      if (d > 4'd9) begin
         r = {3'b000, d} + ASCII_ALPHA_OFS;
      end else begin
         r = {3'b000, d} + ASCII_ZERO;
      end
      return r;
   endfunction

   // Decodes the requested base into a conversion mode.
   function automatic mode_type decode_radix(input logic [7:0] radix);
      mode_type m;
      case (radix)
         BASE_BIN: m = MODE_BIN;
         BASE_DEC: m = MODE_DEC;
         BASE_HEX: m = MODE_HEX;
         default:  m = MODE_ERR;
      endcase
      return m;
   endfunction

endpackage

// ----- hdl/rac_datapath.sv -----
module rac_datapath (
   input  logic                     clock,
   input  rac_pkg::cmd_type         cmd,
   input  logic [63:0]              req_number,
   output rac_pkg::sts_type         sts,
   output rac_pkg::rsp_payload_type rsp_payload
);

   logic [rac_pkg::PAD_W-1:0] work_ff, work_in;
   logic [rac_pkg::BCD_W-1:0] bcd_ff, bcd_in;
   logic [rac_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   rac_pkg::rsp_payload_type  out_ff, out_in;

   logic [3:0]                top_digit;
   logic [rac_pkg::BCD_W-1:0] bcd_adj;
   logic [3:0]                nib;

   // Digit at the head of the active register for the current mode.
   always_comb begin
      case (cmd.mode)
         rac_pkg::MODE_HEX: top_digit = work_ff[rac_pkg::PAD_W-1 -: 4];
         rac_pkg::MODE_BIN: top_digit = {3'b000, work_ff[rac_pkg::PAD_W-1]};
         rac_pkg::MODE_DEC: top_digit = bcd_ff[rac_pkg::BCD_W-1 -: 4];
         default:           top_digit = 4'd0;
      endcase
   end

   assign sts.top_zero = (top_digit == 4'd0);
   assign sts.cnt_one  = (cnt_ff == rac_pkg::CNT_W'(1));

   // Add-3 correction on every BCD digit before the next shift.
   always_comb begin
      for (int i = 0; i < rac_pkg::DEC_DIGITS; i++) begin
         nib = bcd_ff[i*4 +: 4];
         bcd_adj[i*4 +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
      end
   end

   // Next values of the working registers.
   always_comb begin
      work_in = work_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      out_in  = out_ff;
      if (cmd.load) begin
         work_in = rac_pkg::PAD_W'(req_number[rac_pkg::VALUE_WIDTH-1:0]);
         bcd_in  = '0;
         case (cmd.mode)
            rac_pkg::MODE_HEX: cnt_in = rac_pkg::CNT_W'(rac_pkg::HEX_DIGITS);
            default:           cnt_in = rac_pkg::CNT_W'(rac_pkg::PAD_W);
         endcase
      end else if (cmd.dabble) begin
         // One double-dabble step: shift the next value bit into the BCD word.
         bcd_in  = {bcd_adj[rac_pkg::BCD_W-2:0], work_ff[rac_pkg::PAD_W-1]};
         work_in = {work_ff[rac_pkg::PAD_W-2:0], 1'b0};
         cnt_in  = sts.cnt_one ? rac_pkg::CNT_W'(rac_pkg::DEC_DIGITS)
                               : cnt_ff - rac_pkg::CNT_W'(1);
      end else if (cmd.skip || cmd.emit) begin
         // Drop the head digit, whether it is a leading zero or being sent.
         case (cmd.mode)
            rac_pkg::MODE_HEX: work_in = {work_ff[rac_pkg::PAD_W-5:0], 4'd0};
            rac_pkg::MODE_BIN: work_in = {work_ff[rac_pkg::PAD_W-2:0], 1'b0};
            rac_pkg::MODE_DEC: bcd_in  = {bcd_ff[rac_pkg::BCD_W-5:0], 4'd0};
            default:           work_in = work_ff;
         endcase
         cnt_in = cnt_ff - rac_pkg::CNT_W'(1);
      end
      if (cmd.emit) begin
         out_in.digit_char = rac_pkg::to_ascii(top_digit);
         out_in.last_digit = sts.cnt_one;
         out_in.base_error = 1'b0;
      end else if (cmd.emit_err) begin
         out_in.digit_char = 7'd0;
         out_in.last_digit = 1'b1;
         out_in.base_error = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      bcd_ff  <= bcd_in;
      cnt_ff  <= cnt_in;
      out_ff  <= out_in;
   end

   assign rsp_payload = out_ff;

endmodule

// ----- hdl/rac_controller.sv -----
module rac_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [7:0]       req_radix,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rac_pkg::cmd_type cmd,
   input  rac_pkg::sts_type sts
);

   rac_pkg::state_type state_ff, state_in;
   rac_pkg::mode_type  mode_ff, mode_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               slot_free;

   // The output register can take a new result when empty or being drained.
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rac_pkg::ST_IDLE;
         mode_ff      <= rac_pkg::MODE_ERR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      req_stall    = 1'b1;
      cmd          = '0;
      cmd.mode     = mode_ff;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      case (state_ff)
         rac_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.mode  = rac_pkg::decode_radix(req_radix);
            if (req_valid) begin
               cmd.load = 1'b1;
               mode_in  = cmd.mode;
               case (cmd.mode)
                  rac_pkg::MODE_HEX: state_in = rac_pkg::ST_EMIT;
                  rac_pkg::MODE_BIN: state_in = rac_pkg::ST_SKIP;
                  rac_pkg::MODE_DEC: state_in = rac_pkg::ST_DABBLE;
                  default:           state_in = rac_pkg::ST_ERROR;
               endcase
            end
         end
         rac_pkg::ST_DABBLE: begin
            cmd.dabble = 1'b1;
            if (sts.cnt_one) begin
               state_in = rac_pkg::ST_SKIP;
            end
         end
         rac_pkg::ST_SKIP: begin
            // Leading zeros go, but the final digit always stays.
            if (sts.top_zero && !sts.cnt_one) begin
               cmd.skip = 1'b1;
            end else begin
               state_in = rac_pkg::ST_EMIT;
            end
         end
         rac_pkg::ST_EMIT: begin
            if (slot_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               if (sts.cnt_one) begin
                  state_in = rac_pkg::ST_IDLE;
               end
            end
         end
         rac_pkg::ST_ERROR: begin
            if (slot_free) begin
               cmd.emit_err = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = rac_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rac_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   // A dabble pass always hands over to the leading-zero scan.
   a_dabble_to_skip: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rac_pkg::ST_DABBLE && sts.cnt_one) |=> state_ff == rac_pkg::ST_SKIP)
      else $error("dabble pass did not end in the zero scan");

   // A result is only loaded when the output register has room.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit || cmd.emit_err) |-> slot_free)
      else $error("result loaded over a stalled result");

endmodule

// ----- hdl/radix_ascii_converter.sv -----
// Radix ASCII converter.
// The request channel (req_valid, req_stall, req_payload) takes a 64-bit
// number and a base. Bases 2 and 10 give digits without leading zeros and at
// least one digit; base 16 gives 16 uppercase digits with leading zeros; any
// other base gives one response with base_error and last_digit set.
// The response channel (rsp_valid, rsp_stall, rsp_payload) carries one ASCII
// digit per response, most significant first, last_digit marking the end.
// One request is converted at a time; req_stall is low only while idle.
// Steps per request: hex loads the request, then emits its digits.
// Binary loads, skips leading zero bits (up to 63), turns to emitting and
// emits its digits.
// Decimal loads, runs a shift-and-add-3 BCD conversion over the whole value,
// skips leading zero digits (up to 19), turns to emitting and emits its digits.
// The leading-zero scan drops one digit a cycle.
// Each response appears in the cycle after its digit is emitted.
// While rsp_stall is high the held response stays and emitting waits.
// Synchronous reset returns to idle and drops any pending response.
module radix_ascii_converter (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  rac_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rac_pkg::rsp_payload_type rsp_payload
);

   rac_pkg::cmd_type cmd;
   rac_pkg::sts_type sts;

   rac_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_radix (req_payload.radix),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   rac_datapath u_dp (
      .clock       (clock),
      .cmd         (cmd),
      .req_number  (req_payload.number),
      .sts         (sts),
      .rsp_payload (rsp_payload)
   );

   // Only one request is in flight, so acceptance blocks the next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted during a conversion");

   // An error response is always a lone, terminal response with a zero character.
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.base_error) |->
         (rsp_payload.last_digit && rsp_payload.digit_char == 7'd0))
      else $error("malformed error response");

   // Every normal response carries a numeral or an uppercase A to F.
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.base_error) |->
         ((rsp_payload.digit_char >= 7'd48 && rsp_payload.digit_char <= 7'd57) ||
          (rsp_payload.digit_char >= 7'd65 && rsp_payload.digit_char <= 7'd70)))
      else $error("digit character out of range");

endmodule

// ----- tb/rac_digit_checker.sv -----
`timescale 1ns / 1ps

module rac_digit_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  rac_pkg::req_payload_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  rac_pkg::rsp_payload_type rsp_payload,
   output int                       mismatch_count,
   output int                       digits_pending
);

   // Digits still owed by the design, oldest first.
   rac_pkg::rsp_payload_type digit_queue[$];

   // Prints one line for a mismatch and counts it.
   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // Uppercase ASCII character of one digit value.
   function automatic logic [6:0] digit_ascii(input logic [3:0] d);
      logic [6:0] c;
      if (d > 4'd9) begin
         c = {3'b000, d} + rac_pkg::ASCII_ALPHA_OFS;
      end else begin
         c = {3'b000, d} + rac_pkg::ASCII_ZERO;
      end
      return c;
   endfunction

   // Queues every digit that one request should produce.
   function automatic void predict_digits(input rac_pkg::req_payload_type req);
      logic [63:0]              val;
      logic [63:0]              base;
      logic [63:0]              rem;
      logic [6:0]               rev [64];
      int                       count;
      rac_pkg::rsp_payload_type entry;
      val   = req.number & ({64{1'b1}} >> (64 - rac_pkg::VALUE_WIDTH));
      base  = {56'd0, req.radix};
      entry = '0;
      case (req.radix)
         // Hex always gives the full nibble count, leading zeros included.
         rac_pkg::BASE_HEX: begin
            for (int k = 0; k < rac_pkg::HEX_DIGITS; k++) begin
               entry.digit_char = digit_ascii(val[4 * (rac_pkg::HEX_DIGITS - 1 - k) +: 4]);
               entry.last_digit = (k == rac_pkg::HEX_DIGITS - 1);
               digit_queue.push_back(entry);
            end
         end
         // Decimal and binary: divide down, then emit most significant first.
         rac_pkg::BASE_DEC, rac_pkg::BASE_BIN: begin
            count = 0;
            do begin
               rem = val % base;
               rev[count] = digit_ascii(rem[3:0]);
               val = val / base;
               count++;
            end while (val != 0 && count < 64);
            for (int k = count - 1; k >= 0; k--) begin
               entry.digit_char = rev[k];
               entry.last_digit = (k == 0);
               digit_queue.push_back(entry);
            end
         end
         // Any other base gives a single flagged response.
         default: begin
            entry.last_digit = 1'b1;
            entry.base_error = 1'b1;
            digit_queue.push_back(entry);
         end
      endcase
   endfunction

   // Predict on each accepted request and compare each accepted response.
   always @(posedge clock) begin
      rac_pkg::rsp_payload_type want;
      if (reset) begin
         digit_queue.delete();
      end else begin
         if (req_valid && !req_stall) begin
            predict_digits(req_payload);
         end
         if (rsp_valid && !rsp_stall) begin
            if (digit_queue.size() == 0) begin
               report_mismatch($sformatf("response with none expected: char %0d last %0b err %0b",
                               rsp_payload.digit_char, rsp_payload.last_digit,
                               rsp_payload.base_error));
            end else begin
               want = digit_queue.pop_front();
               if (rsp_payload.digit_char !== want.digit_char) begin
                  report_mismatch($sformatf("digit_char %0d, expected %0d",
                                  rsp_payload.digit_char, want.digit_char));
               end
               if (rsp_payload.last_digit !== want.last_digit) begin
                  report_mismatch($sformatf("last_digit %b, expected %b",
                                  rsp_payload.last_digit, want.last_digit));
               end
               if (rsp_payload.base_error !== want.base_error) begin
                  report_mismatch($sformatf("base_error %b, expected %b",
                                  rsp_payload.base_error, want.base_error));
               end
            end
         end
      end
      digits_pending = digit_queue.size();
   end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   // A decimal request runs a BCD pass and a zero scan before it emits.
   localparam int QUIET_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 150;
   localparam int RANDOM_ITEMS = 107;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_stall;
   rac_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall   = 1'b0;
   rac_pkg::rsp_payload_type rsp_payload;
   logic                     idle_on     = 1'b1;
   int                       mismatch_count;
   int                       digits_pending;
   int                       quiet_cycles = 0;

   always #5 clock = ~clock;

   radix_ascii_converter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   rac_digit_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .mismatch_count (mismatch_count),
      .digits_pending (digits_pending)
   );

   // The response side stalls at random while idling is enabled.
   always @(posedge clock) begin
      if (idle_on && $urandom_range(99) < 33) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // End the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[radix_ascii_converter] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one request, with random gaps first, and returns once it is taken.
   task automatic send_request(input logic [63:0] num, input logic [7:0] rad);
      while (idle_on && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{number: num, radix: rad};
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   initial begin
      logic [63:0] num;
      logic [7:0]  rad;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Zero and all ones in every base.
      send_request(64'd0, rac_pkg::BASE_BIN);
      send_request(64'd0, rac_pkg::BASE_DEC);
      send_request(64'd0, rac_pkg::BASE_HEX);
      send_request({64{1'b1}}, rac_pkg::BASE_BIN);
      send_request({64{1'b1}}, rac_pkg::BASE_DEC);
      send_request({64{1'b1}}, rac_pkg::BASE_HEX);
      // Digit count boundaries in decimal and binary.
      send_request(64'd1, rac_pkg::BASE_DEC);
      send_request(64'd9, rac_pkg::BASE_DEC);
      send_request(64'd10, rac_pkg::BASE_DEC);
      send_request(64'd9999999999999999999, rac_pkg::BASE_DEC);
      send_request(64'd10000000000000000000, rac_pkg::BASE_DEC);
      send_request(64'd1, rac_pkg::BASE_BIN);
      send_request(64'h8000_0000_0000_0000, rac_pkg::BASE_BIN);
      // Every hex letter and numeral.
      send_request(64'h0123_4567_89AB_CDEF, rac_pkg::BASE_HEX);
      send_request(64'hFEDC_BA98_7654_3210, rac_pkg::BASE_HEX);
      // Unsupported bases, including those next to the supported ones.
      send_request(64'h1234_5678_9ABC_DEF0, 8'd0);
      send_request(64'd5, 8'd1);
      send_request(64'd5, 8'd3);
      send_request(64'd5, 8'd9);
      send_request(64'd5, 8'd11);
      send_request(64'd5, 8'd15);
      send_request(64'd5, 8'd17);
      send_request({64{1'b1}}, 8'd255);

      // Random requests, with a stretch in the middle where nobody idles.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         idle_on <= !(i >= 40 && i < 80);
         case ($urandom_range(3))
            0:       num = {$urandom, $urandom};
            1:       num = {$urandom, $urandom} >> $urandom_range(63);
            2:       num = 64'($urandom_range(999));
            default: num = 64'd1 << $urandom_range(63);
         endcase
         case ($urandom_range(9))
            0, 1, 2: rad = rac_pkg::BASE_HEX;
            3, 4, 5: rad = rac_pkg::BASE_DEC;
            6, 7, 8: rad = rac_pkg::BASE_BIN;
            default: begin
               do begin
                  rad = 8'($urandom_range(255));
               end while (rad == rac_pkg::BASE_BIN || rad == rac_pkg::BASE_DEC ||
                          rad == rac_pkg::BASE_HEX);
            end
         endcase
         send_request(num, rad);
      end
      req_valid <= 1'b0;
      idle_on   <= 1'b1;

      // Let the checker see the last request, then drain every digit.
      @(posedge clock);
      while (digits_pending != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[radix_ascii_converter] OK");
      end else begin
         $display("[radix_ascii_converter] ERROR");
      end
      $finish;
   end

endmodule
